@@ src/rler_pkg.sv @@
// ----------------------------------------------------------------------------
// rler_pkg
// types and constants shared by the rate limited event ring
// ----------------------------------------------------------------------------
package rler_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [2:0] ResetTokens = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_ID       = 3'd0,
    CFG_CHATTY_FIRST  = 3'd1,
    CFG_CHATTY_SECOND = 3'd2,
    CFG_CHATTY_THIRD  = 3'd3,
    CFG_SUMMARY_TYPE  = 3'd4,
    CFG_NO_NODE_CODE  = 3'd5,
    CFG_BURST_TOKENS  = 3'd6,
    CFG_REFILL_PERIOD = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_APPENDED   = 2'd0,
    STATUS_SUPPRESSED = 2'd1,
    STATUS_READ_VALID = 2'd2,
    STATUS_READ_EMPTY = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CMD_EMIT = 1'b0,
    CMD_READ = 1'b1
  } command_e;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ELAPSED,
    S_DUE,
    S_SWEEP,
    S_EVENT,
    S_TAIL,
    S_LOST,
    S_LOSS_ADD,
    S_HEAD,
    S_FETCH,
    S_FINISH
  } state_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        lt;
  } alu_res_t;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [7:0]  ev_type;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] arg_a;
    logic [15:0] arg_b;
  } entry_t;

  typedef struct packed {
    logic        tok_we;
    logic [2:0]  tok_val;
    logic        sup_we;
    logic [15:0] sup_val;
  } bkt_wr_t;

endpackage

@@ src/rler_alu.sv @@
// ----------------------------------------------------------------------------
// rler_alu
// shared 32-bit add / subtract unit with unsigned less-than flag
// ----------------------------------------------------------------------------
module rler_alu (
  input  rler_pkg::alu_req_t req_i,
  output rler_pkg::alu_res_t res_o
);

  logic [31:0] b_eff;
  logic [32:0] full;
  logic        sub;

  assign sub   = (req_i.op == rler_pkg::ALU_SUB);
  assign b_eff = sub ? ~req_i.b : req_i.b;
  assign full  = {1'b0, req_i.a} + {1'b0, b_eff} + {32'b0, sub};

  assign res_o.sum = full[31:0];
  // borrow on subtract means a < b
  assign res_o.lt  = sub & ~full[32];

endmodule

@@ src/rler_ring.sv @@
// ----------------------------------------------------------------------------
// rler_ring
// event ring storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rler_ring #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(RING_DEPTH)-1:0] waddr_i,
  input  rler_pkg::entry_t              wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(RING_DEPTH)-1:0] raddr_i,
  output rler_pkg::entry_t              rdata_o
);

  rler_pkg::entry_t mem [RING_DEPTH];
  rler_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rler_buckets.sv @@
// ----------------------------------------------------------------------------
// rler_buckets
// per type token buckets and suppression counters, one index per cycle
// ----------------------------------------------------------------------------
module rler_buckets #(
  parameter int unsigned LIMITED_TYPES = 17,
  localparam int unsigned IdxW = (LIMITED_TYPES > 1) ? $clog2(LIMITED_TYPES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IdxW-1:0]   idx_i,
  input  rler_pkg::bkt_wr_t wr_i,
  output logic [2:0]        tok_o,
  output logic [15:0]       sup_o
);

  logic [2:0]  tok_q [LIMITED_TYPES];
  logic [15:0] sup_q [LIMITED_TYPES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LIMITED_TYPES; i++) begin
        tok_q[i] <= rler_pkg::ResetTokens;
        sup_q[i] <= '0;
      end
    end else begin
      if (wr_i.tok_we) begin
        tok_q[idx_i] <= wr_i.tok_val;
      end
      if (wr_i.sup_we) begin
        sup_q[idx_i] <= wr_i.sup_val;
      end
    end
  end

  assign tok_o = tok_q[idx_i];
  assign sup_o = sup_q[idx_i];

endmodule

@@ src/rate_limited_event_ring_top.sv @@
// ----------------------------------------------------------------------------
// rate_limited_event_ring_top
// overwriting event log with per type token bucket rate limiting
// ----------------------------------------------------------------------------
// One word is taken at a time and the input stalls until its result is in the
// output register. All 32-bit arithmetic goes through one shared add/subtract
// unit, one operation per cycle. An emit steps through elapsed, due, event
// and finish; an emit that triggers a refill adds one sweep step per limited
// type between due and event, appending a summary word in the same step for
// each type with a nonzero suppression count. A read steps through tail,
// lost, loss add, head, fetch and finish. Finish waits while the output side
// stalls. The ring is a registered-read memory needing no clearing after reset.
module rate_limited_event_ring_top #(
  parameter int unsigned RING_DEPTH    = 64,
  parameter int unsigned LIMITED_TYPES = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rler_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rler_pkg::CfgDataW-1:0] cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [31:0]                   now_ms_i,
  input  logic [7:0]                    ev_type_i,
  input  logic [7:0]                    ev_src_i,
  input  logic [7:0]                    ev_dst_i,
  input  logic [15:0]                   arg_a_i,
  input  logic [15:0]                   arg_b_i,
  input  logic [31:0]                   read_cursor_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [31:0]                   head_count_o,
  output logic [31:0]                   next_cursor_o,
  output logic [31:0]                   lost_count_o,
  output logic [31:0]                   dropped_total_o,
  output logic [31:0]                   out_time_o,
  output logic [7:0]                    out_type_o,
  output logic [7:0]                    out_src_o,
  output logic [7:0]                    out_dst_o,
  output logic [15:0]                   out_a_o,
  output logic [15:0]                   out_b_o
);

  localparam int unsigned RingW = $clog2(RING_DEPTH);
  localparam int unsigned IdxW  = (LIMITED_TYPES > 1) ? $clog2(LIMITED_TYPES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(LIMITED_TYPES - 1);

  // configuration registers
  logic [7:0]  node_id_q, chatty1_q, chatty2_q, chatty3_q, summary_type_q, no_node_q;
  logic [2:0]  burst_q;
  logic [15:0] period_q;

  // sequencer and state
  rler_pkg::state_e state_q, state_d;
  logic [31:0] count_q, loss_q, last_refill_q, work_q, lost_q;
  logic        started_q, hit_q;
  logic [IdxW-1:0] k_q;
  rler_pkg::status_e status_q;

  // latched input word
  rler_pkg::command_e cmd_q;
  logic [31:0] now_q, cur_q;
  logic [7:0]  ty_q, src_q, dst_q;
  logic [15:0] a_q, b_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  status_out_q;
  logic [31:0] head_out_q, next_cur_out_q, lost_out_q, dropped_out_q;
  rler_pkg::entry_t ent_out_q;

  // datapath
  rler_pkg::alu_req_t alu_req;
  rler_pkg::alu_res_t alu_res;
  rler_pkg::bkt_wr_t  bkt_wr;
  logic [IdxW-1:0]    bkt_idx;
  logic [2:0]         tok_rd;
  logic [15:0]        sup_rd;
  logic               ring_we, ring_re;
  rler_pkg::entry_t   ring_wdata, ring_rdata;
  logic               limited, suppress, due, out_free, in_acc;
  logic [7:0]         self_node;

  rler_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  rler_buckets #(
    .LIMITED_TYPES (LIMITED_TYPES)
  ) u_buckets (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (bkt_idx),
    .wr_i   (bkt_wr),
    .tok_o  (tok_rd),
    .sup_o  (sup_rd)
  );

  rler_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (count_q[RingW-1:0]),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (cur_q[RingW-1:0]),
    .rdata_o (ring_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != rler_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign self_node   = (node_id_q != 8'hFF) ? node_id_q : 8'd1;
  assign limited     = ((ty_q == chatty1_q) || (ty_q == chatty2_q) || (ty_q == chatty3_q))
                       && ({1'b0, ty_q} < 9'(LIMITED_TYPES));
  assign suppress    = limited && (tok_rd == 3'd0);
  assign due         = !started_q || !alu_res.lt;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= 8'd1;
      chatty1_q      <= 8'd0;
      chatty2_q      <= 8'd0;
      chatty3_q      <= 8'd0;
      summary_type_q <= 8'd0;
      no_node_q      <= 8'hFF;
      burst_q        <= 3'd4;
      period_q       <= 16'd1000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (rler_pkg::cfg_reg_e'(cfg_index_i))
        rler_pkg::CFG_NODE_ID:       node_id_q      <= cfg_data_i[7:0];
        rler_pkg::CFG_CHATTY_FIRST:  chatty1_q      <= cfg_data_i[7:0];
        rler_pkg::CFG_CHATTY_SECOND: chatty2_q      <= cfg_data_i[7:0];
        rler_pkg::CFG_CHATTY_THIRD:  chatty3_q      <= cfg_data_i[7:0];
        rler_pkg::CFG_SUMMARY_TYPE:  summary_type_q <= cfg_data_i[7:0];
        rler_pkg::CFG_NO_NODE_CODE:  no_node_q      <= cfg_data_i[7:0];
        rler_pkg::CFG_BURST_TOKENS:  burst_q        <= cfg_data_i[2:0];
        rler_pkg::CFG_REFILL_PERIOD: period_q       <= cfg_data_i[15:0];
        default:                     node_id_q      <= node_id_q;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rler_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (rler_pkg::command_e'(command_i) == rler_pkg::CMD_READ)
                    ? rler_pkg::S_TAIL : rler_pkg::S_ELAPSED;
        end
      end
      rler_pkg::S_ELAPSED:  state_d = rler_pkg::S_DUE;
      rler_pkg::S_DUE:      state_d = due ? rler_pkg::S_SWEEP : rler_pkg::S_EVENT;
      rler_pkg::S_SWEEP: begin
        if (k_q == LastIdx) begin
          state_d = rler_pkg::S_EVENT;
        end
      end
      rler_pkg::S_EVENT:    state_d = rler_pkg::S_FINISH;
      rler_pkg::S_TAIL:     state_d = rler_pkg::S_LOST;
      rler_pkg::S_LOST:     state_d = rler_pkg::S_LOSS_ADD;
      rler_pkg::S_LOSS_ADD: state_d = rler_pkg::S_HEAD;
      rler_pkg::S_HEAD:     state_d = rler_pkg::S_FETCH;
      rler_pkg::S_FETCH:    state_d = rler_pkg::S_FINISH;
      rler_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = rler_pkg::S_IDLE;
        end
      end
      default:              state_d = rler_pkg::S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    alu_req    = '{op: rler_pkg::ALU_ADD, a: count_q, b: 32'd1};
    bkt_idx    = ty_q[IdxW-1:0];
    bkt_wr     = '0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    ring_wdata = '{time_ms: now_q, ev_type: ty_q, src: src_q, dst: dst_q,
                   arg_a: a_q, arg_b: b_q};
    unique case (state_q)
      rler_pkg::S_ELAPSED: begin
        alu_req = '{op: rler_pkg::ALU_SUB, a: now_q, b: last_refill_q};
      end
      rler_pkg::S_DUE: begin
        alu_req = '{op: rler_pkg::ALU_SUB, a: work_q, b: {16'b0, period_q}};
      end
      rler_pkg::S_SWEEP: begin
        bkt_idx        = k_q;
        bkt_wr.tok_we  = 1'b1;
        bkt_wr.tok_val = burst_q;
        bkt_wr.sup_we  = (sup_rd != 16'd0);
        bkt_wr.sup_val = 16'd0;
        ring_we        = (sup_rd != 16'd0);
        ring_wdata     = '{time_ms: now_q, ev_type: summary_type_q, src: self_node,
                           dst: no_node_q, arg_a: 16'(k_q), arg_b: sup_rd};
      end
      rler_pkg::S_EVENT: begin
        if (suppress) begin
          alu_req = '{op: rler_pkg::ALU_ADD, a: {16'b0, sup_rd}, b: 32'd1};
        end
        bkt_wr.tok_we  = limited && !suppress;
        bkt_wr.tok_val = tok_rd - 3'd1;
        bkt_wr.sup_we  = suppress;
        bkt_wr.sup_val = alu_res.sum[15:0];
        ring_we        = !suppress;
      end
      rler_pkg::S_TAIL: begin
        alu_req = '{op: rler_pkg::ALU_SUB, a: count_q, b: 32'(RING_DEPTH)};
      end
      rler_pkg::S_LOST: begin
        alu_req = '{op: rler_pkg::ALU_SUB, a: work_q, b: cur_q};
      end
      rler_pkg::S_LOSS_ADD: begin
        alu_req = '{op: rler_pkg::ALU_ADD, a: loss_q, b: lost_q};
      end
      rler_pkg::S_HEAD: begin
        alu_req = '{op: rler_pkg::ALU_SUB, a: cur_q, b: count_q};
        ring_re = 1'b1;
      end
      rler_pkg::S_FETCH: begin
        alu_req = '{op: rler_pkg::ALU_ADD, a: cur_q, b: 32'd1};
      end
      default: begin
        alu_req = '{op: rler_pkg::ALU_ADD, a: count_q, b: 32'd1};
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= rler_pkg::S_IDLE;
      count_q       <= '0;
      loss_q        <= '0;
      last_refill_q <= '0;
      started_q     <= 1'b0;
      k_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ring_we) begin
        count_q <= alu_res.sum;
      end
      if (state_q == rler_pkg::S_LOSS_ADD) begin
        loss_q <= alu_res.sum;
      end
      if (state_q == rler_pkg::S_DUE) begin
        k_q <= '0;
        if (due) begin
          last_refill_q <= now_q;
          started_q     <= 1'b1;
        end
      end
      if (state_q == rler_pkg::S_SWEEP) begin
        k_q <= k_q + 1'b1;
      end
      if (state_q == rler_pkg::S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= rler_pkg::command_e'(command_i);
      now_q <= now_ms_i;
      ty_q  <= ev_type_i;
      src_q <= ev_src_i;
      dst_q <= ev_dst_i;
      a_q   <= arg_a_i;
      b_q   <= arg_b_i;
      cur_q <= read_cursor_i;
    end
    unique case (state_q)
      rler_pkg::S_ELAPSED: work_q <= alu_res.sum;
      rler_pkg::S_EVENT: begin
        status_q <= suppress ? rler_pkg::STATUS_SUPPRESSED : rler_pkg::STATUS_APPENDED;
      end
      rler_pkg::S_TAIL: begin
        work_q <= (!alu_res.lt && alu_res.sum != 32'd0) ? alu_res.sum : 32'd0;
      end
      rler_pkg::S_LOST: begin
        if (!alu_res.lt && alu_res.sum != 32'd0) begin
          lost_q <= alu_res.sum;
          cur_q  <= work_q;
        end else begin
          lost_q <= 32'd0;
        end
      end
      rler_pkg::S_HEAD: hit_q <= alu_res.lt;
      rler_pkg::S_FETCH: begin
        if (hit_q) begin
          cur_q <= alu_res.sum;
        end
      end
      default: begin
        hit_q <= hit_q;
      end
    endcase
    if (state_q == rler_pkg::S_FINISH && out_free) begin
      head_out_q    <= count_q;
      dropped_out_q <= loss_q;
      if (cmd_q == rler_pkg::CMD_EMIT) begin
        status_out_q   <= status_q;
        next_cur_out_q <= 32'd0;
        lost_out_q     <= 32'd0;
        ent_out_q      <= '0;
      end else begin
        status_out_q   <= hit_q ? rler_pkg::STATUS_READ_VALID : rler_pkg::STATUS_READ_EMPTY;
        next_cur_out_q <= cur_q;
        lost_out_q     <= lost_q;
        ent_out_q      <= hit_q ? ring_rdata : '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_out_q;
  assign head_count_o    = head_out_q;
  assign next_cursor_o   = next_cur_out_q;
  assign lost_count_o    = lost_out_q;
  assign dropped_total_o = dropped_out_q;
  assign out_time_o      = ent_out_q.time_ms;
  assign out_type_o      = ent_out_q.ev_type;
  assign out_src_o       = ent_out_q.src;
  assign out_dst_o       = ent_out_q.dst;
  assign out_a_o         = ent_out_q.arg_a;
  assign out_b_o         = ent_out_q.arg_b;

  // head count only moves on an append step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == rler_pkg::S_SWEEP || $past(state_q) == rler_pkg::S_EVENT))
    else $error("head count changed outside an append step");

  // dropped total only moves in the loss accumulate step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (loss_q != $past(loss_q)) |-> ($past(state_q) == rler_pkg::S_LOSS_ADD))
    else $error("dropped total changed outside the loss step");

  // a new result word is only loaded from the finish step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == rler_pkg::S_FINISH))
    else $error("result word raised outside the finish step");

  // an accepted word starts either the emit or the read sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == rler_pkg::S_ELAPSED || state_q == rler_pkg::S_TAIL))
    else $error("accepted word did not start a sequence");

endmodule

@@ dv/rate_limited_event_ring_top_test.sv @@
// ----------------------------------------------------------------------------
// rate_limited_event_ring_top_test
// self-checking bench for the rate limited event ring
// ----------------------------------------------------------------------------
// Emit and read words go in through the valid/stall input channel. Each
// accepted word is run through a behavioral copy of the ring, the token
// buckets and the refill timer, and its result word is queued. Every result
// word that leaves the block is compared field by field with the oldest one
// queued. The run covers a directed table with register changes between its
// parts, a string of randomly configured phases with random idling on both
// channels and one long output hold-off, and closing phases with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rate_limited_event_ring_top_test;

  localparam int unsigned RingDepth = 64;
  localparam int unsigned LimitedTypes = 17;
  localparam int unsigned ClkPeriod = 8;
  localparam int unsigned DrainCycles = 48;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 3_000_000;

  typedef struct packed {
    rler_pkg::command_e cmd;
    logic [31:0] now;
    logic [7:0]  ev_type;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] a;
    logic [15:0] b;
    logic [31:0] cursor;
  } log_req_t;

  typedef struct packed {
    rler_pkg::status_e status;
    logic [31:0] head;
    logic [31:0] next_cur;
    logic [31:0] lost;
    logic [31:0] dropped;
    logic [31:0] t;
    logic [7:0]  ev_type;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [15:0] a;
    logic [15:0] b;
  } log_rsp_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_WORD,
    ROW_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    rler_pkg::cfg_reg_e idx;
    logic [15:0]        data;
    log_req_t           w;
    log_rsp_t           want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rler_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [rler_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic [7:0] ev_type_i = '0;
  logic [7:0] ev_src_i = '0;
  logic [7:0] ev_dst_i = '0;
  logic [15:0] arg_a_i = '0;
  logic [15:0] arg_b_i = '0;
  logic [31:0] read_cursor_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [31:0] head_count_o;
  logic [31:0] next_cursor_o;
  logic [31:0] lost_count_o;
  logic [31:0] dropped_total_o;
  logic [31:0] out_time_o;
  logic [7:0] out_type_o;
  logic [7:0] out_src_o;
  logic [7:0] out_dst_o;
  logic [15:0] out_a_o;
  logic [15:0] out_b_o;

  // behavioral copy of the log
  rler_pkg::entry_t ring_mem [RingDepth];
  logic [31:0] m_head = '0;
  logic [31:0] m_dropped = '0;
  logic [31:0] m_last_refill = '0;
  logic        m_started = 1'b0;
  logic [2:0]  m_tokens [LimitedTypes];
  logic [15:0] m_supp [LimitedTypes];
  logic [7:0]  m_node = 8'd1;
  logic [7:0]  m_chatty [3];
  logic [7:0]  m_sum_type = 8'd0;
  logic [7:0]  m_no_node = 8'hFF;
  logic [2:0]  m_burst = rler_pkg::ResetTokens;
  logic [15:0] m_period = 16'd1000;

  log_rsp_t    pending_rsp [$];
  plan_row_t   plan [$];
  logic [31:0] t_now = '0;
  logic [31:0] rd_next = '0;
  bit          pace_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned n_cycles = 0;
  int unsigned n_results = 0;
  int unsigned n_err = 0;
  int unsigned n_emits = 0;
  int unsigned n_suppressed = 0;
  int unsigned n_reads = 0;
  int unsigned n_empty = 0;

  rate_limited_event_ring_top dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .now_ms_i,
    .ev_type_i,
    .ev_src_i,
    .ev_dst_i,
    .arg_a_i,
    .arg_b_i,
    .read_cursor_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .head_count_o,
    .next_cursor_o,
    .lost_count_o,
    .dropped_total_o,
    .out_time_o,
    .out_type_o,
    .out_src_o,
    .out_dst_o,
    .out_a_o,
    .out_b_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void ring_push(input rler_pkg::entry_t e);
    ring_mem[m_head % RingDepth] = e;
    m_head = m_head + 32'd1;
  endfunction

  function automatic log_rsp_t ring_predict(input log_req_t w);
    log_rsp_t r;
    rler_pkg::entry_t e;
    logic [31:0] tail;
    logic [31:0] cur;
    int ty;
    int k;
    bit limited;
    r = '0;
    if (w.cmd == rler_pkg::CMD_EMIT) begin
      if (!m_started) begin
        m_started = 1'b1;
        m_last_refill = w.now;
        for (k = 0; k < LimitedTypes; k++) m_tokens[k] = m_burst;
      end
      if (w.now - m_last_refill >= {16'd0, m_period}) begin
        m_last_refill = w.now;
        for (k = 0; k < LimitedTypes; k++) begin
          m_tokens[k] = m_burst;
          if (m_supp[k] != 16'd0) begin
            ring_push('{time_ms: w.now, ev_type: m_sum_type,
                        src: (m_node == 8'hFF) ? 8'd1 : m_node, dst: m_no_node,
                        arg_a: 16'(k), arg_b: m_supp[k]});
            m_supp[k] = '0;
          end
        end
      end
      ty = int'(w.ev_type);
      limited = (w.ev_type == m_chatty[0] || w.ev_type == m_chatty[1] ||
                 w.ev_type == m_chatty[2]) && ty < LimitedTypes;
      r.status = rler_pkg::STATUS_APPENDED;
      if (limited) begin
        if (m_tokens[ty] == 3'd0) begin
          m_supp[ty] = m_supp[ty] + 16'd1;
          r.status = rler_pkg::STATUS_SUPPRESSED;
        end else begin
          m_tokens[ty] = m_tokens[ty] - 3'd1;
        end
      end
      if (r.status == rler_pkg::STATUS_APPENDED) begin
        ring_push('{time_ms: w.now, ev_type: w.ev_type, src: w.src, dst: w.dst,
                    arg_a: w.a, arg_b: w.b});
      end
    end else begin
      tail = (m_head > RingDepth) ? m_head - RingDepth : 32'd0;
      cur = w.cursor;
      if (cur < tail) begin
        r.lost = tail - cur;
        m_dropped = m_dropped + r.lost;
        cur = tail;
      end
      if (cur < m_head) begin
        e = ring_mem[cur % RingDepth];
        r.status = rler_pkg::STATUS_READ_VALID;
        r.t = e.time_ms;
        r.ev_type = e.ev_type;
        r.src = e.src;
        r.dst = e.dst;
        r.a = e.arg_a;
        r.b = e.arg_b;
        cur = cur + 32'd1;
      end else begin
        r.status = rler_pkg::STATUS_READ_EMPTY;
      end
      r.next_cur = cur;
    end
    r.head = m_head;
    r.dropped = m_dropped;
    return r;
  endfunction

  function automatic log_req_t emit_req(input logic [31:0] t, input logic [7:0] ty,
                                        input logic [7:0] src, input logic [7:0] dst,
                                        input logic [15:0] a, input logic [15:0] b);
    log_req_t w;
    w = '0;
    w.cmd = rler_pkg::CMD_EMIT;
    w.now = t;
    w.ev_type = ty;
    w.src = src;
    w.dst = dst;
    w.a = a;
    w.b = b;
    return w;
  endfunction

  function automatic log_req_t read_req(input logic [31:0] c);
    log_req_t w;
    w = '0;
    w.cmd = rler_pkg::CMD_READ;
    w.cursor = c;
    return w;
  endfunction

  function automatic log_rsp_t plain_rsp(input rler_pkg::status_e s, input logic [31:0] head,
                                         input logic [31:0] next_cur);
    log_rsp_t r;
    r = '0;
    r.status = s;
    r.head = head;
    r.next_cur = next_cur;
    return r;
  endfunction

  function automatic void add_word(input log_req_t w);
    plan.push_back('{kind: ROW_WORD, idx: rler_pkg::CFG_NODE_ID, data: '0, w: w, want: '0});
  endfunction

  function automatic void add_typed(input log_req_t w, input log_rsp_t want);
    plan.push_back('{kind: ROW_TYPED, idx: rler_pkg::CFG_NODE_ID, data: '0, w: w,
                     want: want});
  endfunction

  function automatic void add_reg(input rler_pkg::cfg_reg_e idx, input logic [15:0] d);
    plan.push_back('{kind: ROW_REG, idx: idx, data: d, w: '0, want: '0});
  endfunction

  function automatic logic [15:0] pick_chatty();
    logic [7:0] ty;
    ty = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
    return {8'($urandom), ty};
  endfunction

  function automatic void note_fault(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch in %s on result %0d: expected %h, got %h",
               what, n_results, want, got);
    end
  endfunction

  task automatic set_register(input rler_pkg::cfg_reg_e idx, input logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rler_pkg::CFG_NODE_ID: m_node = d[7:0];
      rler_pkg::CFG_CHATTY_FIRST: m_chatty[0] = d[7:0];
      rler_pkg::CFG_CHATTY_SECOND: m_chatty[1] = d[7:0];
      rler_pkg::CFG_CHATTY_THIRD: m_chatty[2] = d[7:0];
      rler_pkg::CFG_SUMMARY_TYPE: m_sum_type = d[7:0];
      rler_pkg::CFG_NO_NODE_CODE: m_no_node = d[7:0];
      rler_pkg::CFG_BURST_TOKENS: m_burst = d[2:0];
      rler_pkg::CFG_REFILL_PERIOD: m_period = d;
      default: ;
    endcase
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic offer_word(input log_req_t w, input bit typed, input log_rsp_t want,
                            output log_rsp_t predicted);
    cfg_valid_i <= 1'b0;
    if (pace_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= w.cmd;
    now_ms_i <= w.now;
    ev_type_i <= w.ev_type;
    ev_src_i <= w.src;
    ev_dst_i <= w.dst;
    arg_a_i <= w.a;
    arg_b_i <= w.b;
    read_cursor_i <= w.cursor;
    do @(posedge clk_i); while (in_stall_o);
    predicted = ring_predict(w);
    pending_rsp.push_back(typed ? want : predicted);
    if (w.cmd == rler_pkg::CMD_EMIT) n_emits++;
    else n_reads++;
    if (predicted.status == rler_pkg::STATUS_SUPPRESSED) n_suppressed++;
    if (predicted.status == rler_pkg::STATUS_READ_EMPTY) n_empty++;
  endtask

  task automatic random_phase(input int ph, input int n_words, input bit calm);
    log_req_t w;
    log_rsp_t p;
    int pick;
    go_idle();
    set_register(rler_pkg::CFG_NODE_ID,
                 ($urandom_range(0, 3) == 0) ? 16'h00FF : 16'($urandom));
    set_register(rler_pkg::CFG_CHATTY_FIRST, pick_chatty());
    set_register(rler_pkg::CFG_CHATTY_SECOND, pick_chatty());
    set_register(rler_pkg::CFG_CHATTY_THIRD, pick_chatty());
    set_register(rler_pkg::CFG_SUMMARY_TYPE, 16'($urandom));
    set_register(rler_pkg::CFG_NO_NODE_CODE, 16'($urandom));
    set_register(rler_pkg::CFG_BURST_TOKENS,
                 (ph == 0) ? 16'd1 : {13'($urandom), 3'($urandom_range(0, 7))});
    set_register(rler_pkg::CFG_REFILL_PERIOD,
                 (ph == 0) ? 16'd1 :
                 ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)));
    pace_on = !calm;
    for (int i = 0; i < n_words; i++) begin
      if (!calm && i % 20 == 0) pace_on = ($urandom_range(0, 3) != 0);
      if (ph == 2 && i == 20) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 62) begin
        case ($urandom_range(0, 19))
          0: t_now = $urandom;
          1: t_now = 32'hFFFF_FFFF - $urandom_range(0, 30);
          default: t_now = t_now + $urandom_range(0, 12);
        endcase
        pick = $urandom_range(0, 9);
        w = emit_req(t_now,
                     (pick < 6) ? m_chatty[$urandom_range(0, 2)] :
                     (pick == 6) ? m_sum_type : 8'($urandom),
                     8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          5: w = read_req(32'd0);
          6: w = read_req($urandom);
          7: w = read_req(m_head);
          8: w = read_req(m_head - $urandom_range(0, 70));
          9: w = read_req(m_head + $urandom_range(1, 3));
          default: w = read_req(rd_next);
        endcase
      end
      offer_word(w, 1'b0, '0, p);
      if (w.cmd == rler_pkg::CMD_READ) rd_next = p.next_cur;
    end
  endtask

  always @(posedge clk_i) begin : watchdog
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : out_side
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (pace_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    log_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_rsp.size() == 0) begin
        note_fault("unexpected word status", 32'd0, 32'(status_o));
      end else begin
        want = pending_rsp.pop_front();
        if (status_o !== want.status) begin
          note_fault("status", 32'(want.status), 32'(status_o));
        end
        if (head_count_o !== want.head) note_fault("head_count", want.head, head_count_o);
        if (next_cursor_o !== want.next_cur) begin
          note_fault("next_cursor", want.next_cur, next_cursor_o);
        end
        if (lost_count_o !== want.lost) note_fault("lost_count", want.lost, lost_count_o);
        if (dropped_total_o !== want.dropped) begin
          note_fault("dropped_total", want.dropped, dropped_total_o);
        end
        if (out_time_o !== want.t) note_fault("out_time", want.t, out_time_o);
        if (out_type_o !== want.ev_type) begin
          note_fault("out_type", 32'(want.ev_type), 32'(out_type_o));
        end
        if (out_src_o !== want.src) note_fault("out_src", 32'(want.src), 32'(out_src_o));
        if (out_dst_o !== want.dst) note_fault("out_dst", 32'(want.dst), 32'(out_dst_o));
        if (out_a_o !== want.a) note_fault("out_a", 32'(want.a), 32'(out_a_o));
        if (out_b_o !== want.b) note_fault("out_b", 32'(want.b), 32'(out_b_o));
      end
    end
  end

  initial begin : stimulus
    log_rsp_t p;
    for (int k = 0; k < LimitedTypes; k++) begin
      m_tokens[k] = rler_pkg::ResetTokens;
      m_supp[k] = '0;
    end
    for (int k = 0; k < 3; k++) m_chatty[k] = 8'd0;

    // reset values: type 0 limited, four tokens, 1000 ms period
    add_typed(read_req(32'd0), plain_rsp(rler_pkg::STATUS_READ_EMPTY, 32'd0, 32'd0));
    add_typed(read_req(32'hFFFF_FFFF),
              plain_rsp(rler_pkg::STATUS_READ_EMPTY, 32'd0, 32'hFFFF_FFFF));
    add_typed(emit_req(32'hFFFF_FF00, 8'd0, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF),
              plain_rsp(rler_pkg::STATUS_APPENDED, 32'd1, 32'd0));
    add_word(emit_req(32'hFFFF_FF00, 8'd0, 8'h00, 8'h00, 16'h0000, 16'h0000));
    add_word(emit_req(32'hFFFF_FF00, 8'd0, 8'h5A, 8'hA5, 16'h5A5A, 16'hA5A5));
    add_word(emit_req(32'hFFFF_FF00, 8'd0, 8'h01, 8'h80, 16'h0001, 16'h8000));
    add_word(emit_req(32'hFFFF_FF00, 8'd0, 8'h11, 8'h22, 16'h3333, 16'h4444));
    // one ms short of the period, across the time wrap
    add_word(emit_req(32'h0000_02E7, 8'd0, 8'h12, 8'h34, 16'h5678, 16'h9ABC));
    add_word(emit_req(32'h0000_02E8, 8'd5, 8'h21, 8'h43, 16'h8765, 16'hCBA9));
    add_word(read_req(32'd4));
    add_word(read_req(32'd5));
    add_word(read_req(32'd6));
    add_word(read_req(32'd0));
    // unset node, zero burst, zero period, one type beyond the limited range
    add_reg(rler_pkg::CFG_NODE_ID, 16'h00FF);
    add_reg(rler_pkg::CFG_CHATTY_FIRST, 16'h0003);
    add_reg(rler_pkg::CFG_CHATTY_SECOND, 16'h0010);
    add_reg(rler_pkg::CFG_CHATTY_THIRD, 16'hFFC8);
    add_reg(rler_pkg::CFG_SUMMARY_TYPE, 16'h00AA);
    add_reg(rler_pkg::CFG_NO_NODE_CODE, 16'h0000);
    add_reg(rler_pkg::CFG_BURST_TOKENS, 16'hFFF8);
    add_reg(rler_pkg::CFG_REFILL_PERIOD, 16'h0000);
    add_word(emit_req(32'h0000_0400, 8'd3, 8'h01, 8'h02, 16'h0003, 16'h0004));
    add_word(emit_req(32'h0000_0400, 8'd16, 8'h05, 8'h06, 16'h0007, 16'h0008));
    add_word(emit_req(32'h0000_0401, 8'd200, 8'h09, 8'h0A, 16'h000B, 16'h000C));
    add_word(read_req(32'd6));
    add_word(read_req(32'd8));
    add_reg(rler_pkg::CFG_NODE_ID, 16'h0000);
    add_reg(rler_pkg::CFG_CHATTY_FIRST, 16'h0011);
    add_reg(rler_pkg::CFG_CHATTY_SECOND, 16'h00FF);
    add_reg(rler_pkg::CFG_CHATTY_THIRD, 16'h0001);
    add_reg(rler_pkg::CFG_SUMMARY_TYPE, 16'h0000);
    add_reg(rler_pkg::CFG_NO_NODE_CODE, 16'h00FF);
    add_reg(rler_pkg::CFG_BURST_TOKENS, 16'h0007);
    add_reg(rler_pkg::CFG_REFILL_PERIOD, 16'hFFFF);
    add_word(emit_req(32'h0000_0500, 8'd1, 8'hFE, 8'hEF, 16'hFEDC, 16'h0123));
    add_word(emit_req(32'h0000_0500, 8'd17, 8'h33, 8'h44, 16'h5555, 16'h6666));
    add_word(emit_req(32'h0000_0500, 8'd255, 8'h77, 8'h88, 16'h9999, 16'hAAAA));
    add_word(emit_req(32'h0001_0400, 8'd1, 8'hBB, 8'hCC, 16'hDDDD, 16'hEEEE));
    add_word(read_req(32'h8000_0000));
    add_word(read_req(32'd9));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (i == 0 || plan[i-1].kind != ROW_REG) go_idle();
        set_register(plan[i].idx, plan[i].data);
      end else begin
        offer_word(plan[i].w, plan[i].kind == ROW_TYPED, plan[i].want, p);
      end
    end

    t_now = 32'h0002_0000;
    for (int ph = 0; ph < 6; ph++) random_phase(ph, 66, 1'b0);
    for (int ph = 6; ph < 8; ph++) random_phase(ph, 66, 1'b1);
    go_idle();

    $display("checked %0d result words: %0d emits (%0d suppressed), %0d reads (%0d empty)",
             n_results, n_emits, n_suppressed, n_reads, n_empty);
    $display("ring head ended at %0d, readers lost %0d entries behind the tail",
             m_head, m_dropped);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rler_pkg.sv
src/rler_alu.sv
src/rler_ring.sv
src/rler_buckets.sv
src/rate_limited_event_ring_top.sv
dv/rate_limited_event_ring_top_test.sv
